[sv/assert_macros.svh]
// assertion macros shared by the parser rtl
// all checks sample on clk and are held off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

[sv/hdlp_pkg.sv]
// shared types, constants and helpers for the hex dump line parser
// no dependencies
package hdlp_pkg;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] WS_MAX   = 8'h20;

  localparam logic [3:0] COL_FIRST       = 4'd0;
  localparam logic [3:0] COL_SECOND      = 4'd1;
  localparam logic [3:0] COL_SHORT_COLON = 4'd8;
  localparam logic [3:0] COL_SHORT_DATA  = 4'd9;
  localparam logic [3:0] COL_LONG_COLON  = 4'd10;
  localparam logic [3:0] COL_LONG_DATA   = 4'd11;
  localparam logic [3:0] COL_MAX         = 4'd15;

  localparam logic [1:0] PH_SPACE = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       dump_end;
  } out_item_t;

  typedef struct packed {
    logic       finished;
    logic       in_leading_blank;
    logic [3:0] column;
    logic       starts_zero;
    logic       second_is_x;
    logic       short_prefix_ok;
    logic       long_prefix_ok;
    logic       triplets_live;
    logic [1:0] triplet_phase;
    logic [3:0] high_nibble;
  } line_state_t;

  // state after reset: not finished, waiting in leading blanks
  localparam line_state_t LINE_RESET = '{1'b0, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                         2'd0, 4'd0};

  typedef struct packed {
    logic       finished;
    logic       long_prefix_ok;
    logic [3:0] column;
  } core_status_t;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] n;
    n = 5'h10;
    if (c inside {[8'h30:8'h39]}) n = {1'b0, 4'(c - 8'h30)};
    else if (c inside {[8'h41:8'h46]}) n = {1'b0, 4'(c - 8'h37)};
    else if (c inside {[8'h61:8'h66]}) n = {1'b0, 4'(c - 8'h57)};
    return n;
  endfunction

endpackage

[sv/hdlp_core.sv]
// line state registers and the per-item parse step
// depends on hdlp_pkg
module hdlp_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  hdlp_pkg::in_item_t    item,
  output logic                  res_hit,
  output hdlp_pkg::out_item_t   res,
  output hdlp_pkg::core_status_t status
);

  hdlp_pkg::line_state_t st;
  hdlp_pkg::line_state_t st_next;
  hdlp_pkg::line_state_t line_clear;
  logic [3:0] idx;
  logic [4:0] nib;

  always_comb begin
    line_clear = '0;
    line_clear.finished = st.finished;
    line_clear.in_leading_blank = 1'b1;
  end

  always_comb begin
    st_next = st;
    res_hit = 1'b0;
    res = '0;
    idx = st.column;
    nib = hdlp_pkg::nibble_of(item.char_code);
    if (!st.finished) begin
      if (item.kind == hdlp_pkg::KIND_EOL) begin
        st_next = line_clear;
        if (st.in_leading_blank) begin
          // blank line closes the dump
          st_next.finished = 1'b1;
          res_hit = 1'b1;
          res.dump_end = 1'b1;
        end
      end else if (!(st.in_leading_blank && item.char_code <= hdlp_pkg::WS_MAX)) begin
        st_next.in_leading_blank = 1'b0;
        if (st.column != hdlp_pkg::COL_MAX) st_next.column = st.column + 4'd1;
        if (idx == hdlp_pkg::COL_FIRST)
          st_next.starts_zero = (item.char_code == hdlp_pkg::CH_ZERO);
        if (idx == hdlp_pkg::COL_SECOND)
          st_next.second_is_x = (item.char_code == hdlp_pkg::CH_X);
        if (idx == hdlp_pkg::COL_SHORT_COLON)
          st_next.short_prefix_ok = st.starts_zero && (item.char_code == hdlp_pkg::CH_COLON);
        if (idx == hdlp_pkg::COL_SHORT_DATA && st.short_prefix_ok) begin
          st_next.triplets_live = 1'b1;
          st_next.triplet_phase = hdlp_pkg::PH_SPACE;
        end
        if (idx == hdlp_pkg::COL_LONG_COLON && st.starts_zero && st.second_is_x &&
            item.char_code == hdlp_pkg::CH_COLON) begin
          // long prefix restarts decoding
          st_next.long_prefix_ok = 1'b1;
          st_next.triplets_live = 1'b1;
          st_next.triplet_phase = hdlp_pkg::PH_SPACE;
        end else if (st_next.triplets_live) begin
          case (st_next.triplet_phase)
            hdlp_pkg::PH_SPACE: begin
              if (item.char_code == hdlp_pkg::CH_SPACE)
                st_next.triplet_phase = hdlp_pkg::PH_HIGH;
              else
                st_next.triplets_live = 1'b0;
            end
            hdlp_pkg::PH_HIGH, hdlp_pkg::PH_LOW: begin
              if (nib[4]) begin
                st_next.triplets_live = 1'b0;
                st_next.triplet_phase = hdlp_pkg::PH_SPACE;
              end else if (st_next.triplet_phase == hdlp_pkg::PH_HIGH) begin
                st_next.high_nibble = nib[3:0];
                st_next.triplet_phase = hdlp_pkg::PH_LOW;
              end else begin
                st_next.triplet_phase = hdlp_pkg::PH_SPACE;
                res_hit = 1'b1;
                res.data_byte = {st.high_nibble, nib[3:0]};
              end
            end
            default: begin
              st_next.triplets_live = 1'b0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= hdlp_pkg::LINE_RESET;
    end else if (step) begin
      st <= st_next;
    end
  end

  assign status.finished = st.finished;
  assign status.long_prefix_ok = st.long_prefix_ok;
  assign status.column = st.column;

endmodule

[sv/hex_dump_line_parser.sv]
// Hex dump line parser. Takes one character (or end-of-line mark) per item and returns
// one decoded byte per space-hex-hex triplet on lines with a valid address prefix, or a
// single end item when a blank line closes the dump; after that nothing more comes out
// until reset. One item is accepted every cycle when the result side keeps up; an item
// goes through an input register and the parse step into the result register, from
// which its result is presented. While a result waits, the input register still takes
// one more item.
// depends on hdlp_pkg, hdlp_core and assert_macros.svh
`include "assert_macros.svh"

module hex_dump_line_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  hdlp_pkg::in_item_t  char_item,
  output logic                res_valid,
  input  logic                res_ready,
  output hdlp_pkg::out_item_t res_item
);

  logic                   held_valid;
  hdlp_pkg::in_item_t     held_item;
  logic                   advance;
  logic                   step_hit;
  hdlp_pkg::out_item_t    step_res;
  hdlp_pkg::core_status_t status;

  assign advance    = held_valid && (!res_valid || res_ready);
  assign char_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (char_ready) begin
      held_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) held_item <= char_item;
  end

  hdlp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (held_item),
    .res_hit(step_hit),
    .res    (step_res),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && step_hit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_hit) res_item <= step_res;
  end

  `ASSERT_NEXT(a_finished_sticks, status.finished, status.finished)
  `ASSERT_NEXT(a_no_result_after_end, status.finished && !res_valid, !res_valid)
  `ASSERT_IMPLIES(a_end_has_zero_byte, res_valid && res_item.dump_end, res_item.data_byte == 8'd0)
  `ASSERT_IMPLIES(a_long_prefix_column, status.long_prefix_ok, status.column >= hdlp_pkg::COL_LONG_DATA)

endmodule

[test/dump_byte_checker.sv]
`timescale 1ns / 100ps
// checker for the hex dump line parser: follows both channels, predicts each result
// from the accepted characters and compares. depends on hdlp_pkg
module dump_byte_checker
  import hdlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  input  logic      char_ready,
  input  in_item_t  char_item,
  input  logic      res_valid,
  input  logic      res_ready,
  input  out_item_t res_item,
  output int        mismatches,
  output int        bytes_due
);

  line_state_t line_st;
  out_item_t   expected_q[$];
  int          n_bad = 0;

  function automatic line_state_t fresh_line(input logic done);
    line_state_t s;
    s = '0;
    s.finished = done;
    s.in_leading_blank = 1'b1;
    return s;
  endfunction

  // bit 4 flags a character that is not a hex digit
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    if (c >= CH_ZERO && c <= 8'h39) return {1'b0, c[3:0]};
    if (folded >= 8'h61 && folded <= 8'h66) return {1'b0, 4'(c[3:0] + 4'd9)};
    return 5'h10;
  endfunction

  // advances the line state by one item; returns 1 when the item yields a result
  function automatic bit parse_char(input in_item_t it, output out_item_t res);
    logic [3:0] idx;
    logic [4:0] nib;
    logic [7:0] c;
    res = '0;
    c = it.char_code;
    if (line_st.finished) return 1'b0;
    if (it.kind == KIND_EOL) begin
      if (line_st.in_leading_blank) begin
        line_st = fresh_line(1'b1);
        res.dump_end = 1'b1;
        return 1'b1;
      end
      line_st = fresh_line(1'b0);
      return 1'b0;
    end
    if (line_st.in_leading_blank) begin
      if (c <= WS_MAX) return 1'b0;
      line_st.in_leading_blank = 1'b0;
    end
    idx = line_st.column;
    if (line_st.column != COL_MAX) line_st.column = line_st.column + 4'd1;
    if (idx == COL_FIRST) line_st.starts_zero = (c == CH_ZERO);
    if (idx == COL_SECOND) line_st.second_is_x = (c == CH_X);
    if (idx == COL_SHORT_COLON) line_st.short_prefix_ok = line_st.starts_zero && (c == CH_COLON);
    if (idx == COL_SHORT_DATA && line_st.short_prefix_ok) begin
      line_st.triplets_live = 1'b1;
      line_st.triplet_phase = PH_SPACE;
    end
    // long prefix restarts decoding after its colon
    if (idx == COL_LONG_COLON && line_st.starts_zero && line_st.second_is_x
        && c == CH_COLON) begin
      line_st.long_prefix_ok = 1'b1;
      line_st.triplets_live = 1'b1;
      line_st.triplet_phase = PH_SPACE;
      return 1'b0;
    end
    if (!line_st.triplets_live) return 1'b0;
    if (line_st.triplet_phase == PH_SPACE) begin
      if (c == CH_SPACE) line_st.triplet_phase = PH_HIGH;
      else line_st.triplets_live = 1'b0;
      return 1'b0;
    end
    nib = digit_value(c);
    if (nib[4]) begin
      line_st.triplets_live = 1'b0;
      line_st.triplet_phase = PH_SPACE;
      return 1'b0;
    end
    if (line_st.triplet_phase == PH_HIGH) begin
      line_st.high_nibble = nib[3:0];
      line_st.triplet_phase = PH_LOW;
      return 1'b0;
    end
    line_st.triplet_phase = PH_SPACE;
    res.data_byte = {line_st.high_nibble, nib[3:0]};
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    bit bad;
    if (rst) begin
      line_st = fresh_line(1'b0);
      expected_q.delete();
    end else begin
      // compare before taking the new item, so a fresh prediction cannot mask a stray result
      if (res_valid && res_ready) begin
        got = res_item;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, got data_byte %h dump_end %b",
                   $time, got.data_byte, got.dump_end);
          n_bad++;
        end else begin
          want = expected_q.pop_front();
          bad = 1'b0;
          if (got.data_byte !== want.data_byte) begin
            $display("%0t: data_byte expected %h got %h", $time, want.data_byte, got.data_byte);
            bad = 1'b1;
          end
          if (got.dump_end !== want.dump_end) begin
            $display("%0t: dump_end expected %b got %b", $time, want.dump_end, got.dump_end);
            bad = 1'b1;
          end
          if (bad) n_bad++;
        end
      end
      if (char_valid && char_ready) begin
        if (parse_char(char_item, want)) expected_q.push_back(want);
      end
    end
    mismatches <= n_bad;
    bytes_due  <= expected_q.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// top of the hex dump line parser test: clock, reset, character stimulus and verdict
// depends on hdlp_pkg, hex_dump_line_parser and dump_byte_checker
module testbench;
  import hdlp_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 460;
  localparam int DRAIN_CYCLES  = 20;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      char_valid = 1'b0;
  logic      char_ready;
  in_item_t  char_item = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  out_item_t res_item;

  int mismatches;
  int bytes_due;
  int cycles = 0;
  int n_sent = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int idle_tab[4]  = '{0, 85, 0, 9};
  int stall_tab[4] = '{0, 0, 85, 9};

  hex_dump_line_parser dut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_item (char_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  dump_byte_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_item (char_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .mismatches(mismatches),
    .bytes_due (bytes_due)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) res_ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v - 4'd10);
  endfunction

  task automatic send_char(input logic kind, input logic [7:0] code);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      char_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    char_item  <= in_item_t'({kind, code});
    char_valid <= 1'b1;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(KIND_CHAR, s[i]);
  endtask

  // one random line, mostly a well formed dump line; never blank
  task automatic send_line();
    int style;
    int n_trip;
    int k;
    logic [7:0] c;
    repeat ($urandom_range(3)) send_char(KIND_CHAR, 8'($urandom_range(32)));
    style = $urandom_range(99);
    if (style < 85) begin
      send_char(KIND_CHAR, CH_ZERO);
      if (style < 35) begin
        send_char(KIND_CHAR, CH_X);
        repeat (8) send_char(KIND_CHAR, hex_char(4'($urandom)));
        send_char(KIND_CHAR, CH_COLON);
      end else if (style < 70) begin
        repeat (7) send_char(KIND_CHAR, hex_char(4'($urandom)));
        send_char(KIND_CHAR, CH_COLON);
      end else if (style < 78) begin
        // short colon at column 8 and long colon at column 10 on the same line
        send_char(KIND_CHAR, CH_X);
        repeat (6) send_char(KIND_CHAR, hex_char(4'($urandom)));
        send_char(KIND_CHAR, CH_COLON);
        send_char(KIND_CHAR, $urandom_range(1) ? CH_SPACE : hex_char(4'($urandom)));
        send_char(KIND_CHAR, CH_COLON);
      end else begin
        // long prefix with one stray character
        k = $urandom_range(1, 10);
        for (int i = 1; i <= 10; i++) begin
          c = (i == 1) ? CH_X : (i == 10) ? CH_COLON : hex_char(4'($urandom));
          if (i == k) c = 8'($urandom);
          send_char(KIND_CHAR, c);
        end
      end
      n_trip = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(6);
      repeat (n_trip) begin
        k = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
        send_char(KIND_CHAR, (k == 1) ? 8'($urandom) : CH_SPACE);
        send_char(KIND_CHAR, (k == 2) ? 8'($urandom) : hex_char(4'($urandom)));
        send_char(KIND_CHAR, (k == 3) ? 8'($urandom) : hex_char(4'($urandom)));
      end
    end else begin
      send_char(KIND_CHAR, 8'($urandom_range(33, 255)));
      repeat ($urandom_range(20)) send_char(KIND_CHAR, 8'($urandom));
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) send_char(KIND_CHAR, 8'($urandom));
    send_char(KIND_EOL, 8'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // leading blanks at both ends of the range, long and short form, byte extremes
    send_char(KIND_CHAR, 8'h00);
    send_char(KIND_CHAR, WS_MAX);
    send_text("0x0000ffff: ff 00");
    send_char(KIND_EOL, 8'hff);
    send_text("0abcdef9: A5");
    send_char(KIND_EOL, 8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = idle_tab[ph];
      recv_stall = stall_tab[ph];
      while (n_sent < (ph + 1) * PHASE_ITEMS) send_line();
      // hold the sender until every due byte has come out
      char_valid <= 1'b0;
      @(posedge clk);
      while (bytes_due != 0) @(posedge clk);
    end

    // blank line closes the dump, everything after it is ignored
    send_idle  = 9;
    recv_stall = 9;
    repeat ($urandom_range(3)) send_char(KIND_CHAR, 8'($urandom_range(32)));
    send_char(KIND_EOL, 8'($urandom));
    repeat (6) send_char(1'($urandom), 8'($urandom));
    send_char(KIND_EOL, 8'h00);

    char_valid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && bytes_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
